// ----- src/tone_glide_divisor_generator_core_assert.svh -----
// Assertion macros for the tone glide divisor generator.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef TONE_GLIDE_DIVISOR_GENERATOR_CORE_ASSERT_SVH
`define TONE_GLIDE_DIVISOR_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGD_ASSERT_IMPLIES(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGD_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

// ----- src/tgd_pkg.sv -----
// Shared constants, codes, the octave-four frequency table and the divider status type
// for the tone glide divisor generator. No dependencies.
package tgd_pkg;

   localparam int FREQ_FRAC_BITS_DEF = 12;
   localparam int DURATION_BITS_DEF  = 16;
   localparam int TABLE_FRAC         = 16;
   localparam int TABLE_WIDTH        = 25;
   localparam int TIMER_DIV_WIDTH    = 16;
   localparam int CLOCK_HZ_WIDTH     = 24;
   localparam int TICK_MS_WIDTH      = 8;
   localparam int CSR_DATA_WIDTH     = 24;
   localparam int T_FRAC             = 16;

   localparam logic [CLOCK_HZ_WIDTH-1:0] CLOCK_HZ_RESET = 24'd1193180;
   localparam logic [TICK_MS_WIDTH-1:0]  TICK_MS_RESET  = 8'd1;

   localparam logic CSR_CLOCK_HZ = 1'b0;
   localparam logic CSR_TICK_MS  = 1'b1;

   localparam logic [1:0] KIND_NOTE  = 2'd0;
   localparam logic [1:0] KIND_SLIDE = 2'd1;
   localparam logic [1:0] KIND_PAUSE = 2'd2;
   localparam logic [1:0] KIND_TICK  = 2'd3;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_NOTE  = 2'd1;
   localparam logic [1:0] MODE_SLIDE = 2'd2;
   localparam logic [1:0] MODE_PAUSE = 2'd3;

   localparam logic [1:0] CURVE_LINEAR   = 2'd0;
   localparam logic [1:0] CURVE_SMOOTH   = 2'd1;
   localparam logic [1:0] CURVE_EASE_OUT = 2'd2;
   localparam logic [1:0] CURVE_EASE_IN  = 2'd3;

   typedef logic [TABLE_WIDTH-1:0] semitone_table_type [12];

   // Octave four, C through B, in unsigned Q.16 hertz.
   localparam semitone_table_type OCTAVE4_Q16 = '{
      25'd17145893, 25'd18165441, 25'd19245614, 25'd20390018,
      25'd21602472, 25'd22887021, 25'd24247954, 25'd25689813,
      25'd27217409, 25'd28835840, 25'd30550508, 25'd32367136
   };

   typedef struct packed {
      logic busy;
      logic done;
      logic overflow;
   } div_status_type;

endpackage

// ----- src/tone_glide_divisor_generator_core.sv -----
// Top level of the tone glide divisor generator: command decode, slide sequencer,
// shared multiplier and result register. Depends on tgd_pkg, tgd_divider and the assert header.
//
//   channel   direction   handshake              beat content
//   req       in          req_valid/req_ready    kind, start/end note, curve, duration_ms
//   rsp       out         rsp_valid/rsp_ready    divisor, speaker_on, busy_res
//   csr       in          csr_write_enable       clock_hz (index 0), tick_ms (index 1)
//
// The single restoring divider, one bit a cycle, divides clock_hz by the start frequency for
// a note or nonzero slide start. A slide tick divides elapsed by length, shapes it by the curve,
// then divides clock_hz by the slide frequency. Pauses and other ticks skip the divider.
// Reset is synchronous: it clears the mode, the divisor and rsp_valid, and reloads both CSRs.
// A waiting result does not block the next beat; only its completion waits for the result slot.
`include "tone_glide_divisor_generator_core_assert.svh"

module tone_glide_divisor_generator_core
   import tgd_pkg::*;
#(
   parameter int FREQ_FRAC_BITS = FREQ_FRAC_BITS_DEF,
   parameter int DURATION_BITS  = DURATION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [3:0]                req_start_semitone,
   input  logic [3:0]                req_start_octave,
   input  logic [3:0]                req_end_semitone,
   input  logic [3:0]                req_end_octave,
   input  logic [1:0]                req_curve,
   input  logic [15:0]               req_duration_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_divisor,
   output logic                      rsp_speaker_on,
   output logic                      rsp_busy_res
);

   localparam int FW   = 14 + FREQ_FRAC_BITS;
   localparam int DW   = DURATION_BITS;
   localparam int WW   = TABLE_WIDTH + 16;
   localparam int NW_H = CLOCK_HZ_WIDTH + FREQ_FRAC_BITS;
   localparam int NW_T = DW + T_FRAC;
   localparam int NW   = (NW_H > NW_T) ? NW_H : NW_T;
   localparam int MW   = (FW > DW) ? FW : DW;
   localparam int PW   = FW + 18;
   localparam logic [4:0]  RSH_BASE = 5'(TABLE_FRAC + 4 - FREQ_FRAC_BITS);
   localparam logic [16:0] T_ONE    = 17'h10000;
   localparam logic [17:0] T_THREE  = 18'h30000;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TDIV   = 4'd1;
   localparam logic [3:0] S_MUL1   = 4'd2;
   localparam logic [3:0] S_CURV   = 4'd3;
   localparam logic [3:0] S_SMOOTH = 4'd4;
   localparam logic [3:0] S_DIFF   = 4'd5;
   localparam logic [3:0] S_FREQ   = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   function automatic logic [FW-1:0] note_freq(input logic [3:0] semi, input logic [3:0] oct);
      logic [3:0]    s;
      logic [4:0]    o;
      logic [WW-1:0] wide;
      s = semi;
      o = {1'b0, oct};
      if (semi >= 4'd12) begin
         s = semi - 4'd12;
         o = o + 5'd1;
      end
      wide = WW'(OCTAVE4_Q16[s]);
      if (o >= RSH_BASE) begin
         wide = wide << (o - RSH_BASE);
      end else begin
         wide = wide >> (RSH_BASE - o);
      end
      if (wide[WW-1:FW] != '0) begin
         note_freq = '1;
      end else begin
         note_freq = wide[FW-1:0];
      end
   endfunction

   logic [3:0]                state_ff, state_in;
   logic [1:0]                mode_ff, mode_in;
   logic [15:0]               cur_div_ff, cur_div_in;
   logic [CLOCK_HZ_WIDTH-1:0] clock_hz_ff, clock_hz_in;
   logic [TICK_MS_WIDTH-1:0]  tick_ms_ff, tick_ms_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               rsp_divisor_ff, rsp_divisor_in;
   logic                      rsp_speaker_on_ff, rsp_speaker_on_in;
   logic                      rsp_busy_res_ff, rsp_busy_res_in;
   logic [1:0]                curve_ff, curve_in;
   logic [DW-1:0]             elapsed_ff, elapsed_in;
   logic [DW-1:0]             length_ff, length_in;
   logic [FW-1:0]             start_freq_ff, start_freq_in;
   logic [FW-1:0]             end_freq_ff, end_freq_in;
   logic [FW-1:0]             diff_ff, diff_in;
   logic                      rise_ff, rise_in;
   logic [15:0]               t_ff, t_in;
   logic [16:0]               g_ff, g_in;
   logic [PW-1:0]             prod_ff, prod_in;

   logic                      accept;
   logic [FW-1:0]             freq_start;
   logic [FW-1:0]             freq_end;
   logic [DW-1:0]             req_len;
   logic [DW:0]               el_sum;
   logic [DW-1:0]             el_next;
   logic [16:0]               sq_op;
   logic [16:0]               sq_hi;
   logic [FW-1:0]             slide_d;
   logic [FW-1:0]             slide_f;
   logic [FW-1:0]             mul_a;
   logic [17:0]               mul_b;
   logic [PW-1:0]             prod_mul;
   logic                      div_start;
   logic [NW-1:0]             div_num;
   logic [MW-1:0]             div_den;
   logic [15:0]               div_quo;
   div_status_type            div_stat;

   tgd_divider #(
      .NUM_WIDTH (NW),
      .DEN_WIDTH (MW),
      .QUO_WIDTH (TIMER_DIV_WIDTH)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .quotient    (div_quo),
      .status      (div_stat)
   );

   if (DURATION_BITS >= 16) begin : g_dur_wide
      assign req_len = DW'(req_duration_ms);
   end else begin : g_dur_narrow
      assign req_len = ((req_duration_ms >> DURATION_BITS) != 16'd0) ? '1
                                                                     : req_duration_ms[DW-1:0];
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid & req_ready;
   assign freq_start = note_freq(req_start_semitone, req_start_octave);
   assign freq_end   = note_freq(req_end_semitone, req_end_octave);
   assign el_sum     = {1'b0, elapsed_ff} + (DW+1)'(tick_ms_ff);
   assign el_next    = el_sum[DW] ? '1 : el_sum[DW-1:0];
   assign sq_op      = (curve_ff == CURVE_EASE_OUT) ? (T_ONE - {1'b0, t_ff}) : {1'b0, t_ff};
   assign sq_hi      = prod_ff[32:16];
   assign slide_d    = prod_ff[FW+15:16];
   assign slide_f    = rise_ff ? (start_freq_ff + slide_d) : (start_freq_ff - slide_d);
   assign prod_mul   = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      clock_hz_in = clock_hz_ff;
      tick_ms_in  = tick_ms_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CLOCK_HZ: clock_hz_in = csr_write_data[CLOCK_HZ_WIDTH-1:0];
            CSR_TICK_MS:  tick_ms_in  = csr_write_data[TICK_MS_WIDTH-1:0];
            default:      clock_hz_in = clock_hz_ff;
         endcase
      end
   end

   always_comb begin
      state_in          = state_ff;
      mode_in           = mode_ff;
      cur_div_in        = cur_div_ff;
      curve_in          = curve_ff;
      elapsed_in        = elapsed_ff;
      length_in         = length_ff;
      start_freq_in     = start_freq_ff;
      end_freq_in       = end_freq_ff;
      diff_in           = diff_ff;
      rise_in           = rise_ff;
      t_in              = t_ff;
      g_in              = g_ff;
      prod_in           = prod_ff;
      mul_a             = '0;
      mul_b             = '0;
      div_start         = 1'b0;
      div_num           = '0;
      div_den           = '0;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;
      rsp_divisor_in    = rsp_divisor_ff;
      rsp_speaker_on_in = rsp_speaker_on_ff;
      rsp_busy_res_in   = rsp_busy_res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_NOTE: begin
                     start_freq_in = freq_start;
                     end_freq_in   = freq_start;
                     elapsed_in    = '0;
                     length_in     = req_len;
                     mode_in       = (req_len != '0) ? MODE_NOTE : MODE_IDLE;
                     div_start     = 1'b1;
                     div_num       = NW'({clock_hz_ff, {FREQ_FRAC_BITS{1'b0}}});
                     div_den       = MW'(freq_start);
                     state_in      = S_DIV;
                  end
                  KIND_SLIDE: begin
                     start_freq_in = freq_start;
                     end_freq_in   = freq_end;
                     curve_in      = req_curve;
                     elapsed_in    = '0;
                     length_in     = req_len;
                     if (req_len != '0) begin
                        mode_in   = MODE_SLIDE;
                        div_start = 1'b1;
                        div_num   = NW'({clock_hz_ff, {FREQ_FRAC_BITS{1'b0}}});
                        div_den   = MW'(freq_start);
                        state_in  = S_DIV;
                     end else begin
                        mode_in  = MODE_IDLE;
                        state_in = S_DONE;
                     end
                  end
                  KIND_PAUSE: begin
                     elapsed_in = '0;
                     length_in  = req_len;
                     mode_in    = (req_len != '0) ? MODE_PAUSE : MODE_IDLE;
                     state_in   = S_DONE;
                  end
                  KIND_TICK: begin
                     state_in = S_DONE;
                     if (mode_ff != MODE_IDLE) begin
                        elapsed_in = el_next;
                        if (el_next >= length_ff) begin
                           mode_in = MODE_IDLE;
                        end else if (mode_ff == MODE_SLIDE) begin
                           div_start = 1'b1;
                           div_num   = NW'({el_next, {T_FRAC{1'b0}}});
                           div_den   = MW'(length_ff);
                           state_in  = S_TDIV;
                        end
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_TDIV: begin
            if (div_stat.done) begin
               t_in     = div_quo;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            mul_a    = FW'(sq_op);
            mul_b    = {1'b0, sq_op};
            prod_in  = prod_mul;
            rise_in  = (end_freq_ff >= start_freq_ff);
            diff_in  = (end_freq_ff >= start_freq_ff) ? (end_freq_ff - start_freq_ff)
                                                      : (start_freq_ff - end_freq_ff);
            state_in = S_CURV;
         end
         S_CURV: begin
            state_in = S_DIFF;
            unique case (curve_ff)
               CURVE_LINEAR:   g_in = {1'b0, t_ff};
               CURVE_SMOOTH: begin
                  mul_a    = FW'(sq_hi);
                  mul_b    = T_THREE - {1'b0, t_ff, 1'b0};
                  prod_in  = prod_mul;
                  state_in = S_SMOOTH;
               end
               CURVE_EASE_OUT: g_in = T_ONE - sq_hi;
               CURVE_EASE_IN:  g_in = sq_hi;
               default:        g_in = {1'b0, t_ff};
            endcase
         end
         S_SMOOTH: begin
            g_in     = sq_hi;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            mul_a    = diff_ff;
            mul_b    = {1'b0, g_ff};
            prod_in  = prod_mul;
            state_in = S_FREQ;
         end
         S_FREQ: begin
            div_start = 1'b1;
            div_num   = NW'({clock_hz_ff, {FREQ_FRAC_BITS{1'b0}}});
            div_den   = MW'(slide_f);
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               cur_div_in = div_stat.overflow ? '1 : div_quo;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_divisor_in    = cur_div_ff;
               rsp_speaker_on_in = (mode_ff == MODE_NOTE) || (mode_ff == MODE_SLIDE);
               rsp_busy_res_in   = (mode_ff != MODE_IDLE);
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_IDLE;
         cur_div_ff   <= '0;
         clock_hz_ff  <= CLOCK_HZ_RESET;
         tick_ms_ff   <= TICK_MS_RESET;
         rsp_valid_ff <= 1'b0;
         curve_ff     <= CURVE_LINEAR;
         elapsed_ff   <= '0;
         length_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cur_div_ff   <= cur_div_in;
         clock_hz_ff  <= clock_hz_in;
         tick_ms_ff   <= tick_ms_in;
         rsp_valid_ff <= rsp_valid_in;
         curve_ff     <= curve_in;
         elapsed_ff   <= elapsed_in;
         length_ff    <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      start_freq_ff     <= start_freq_in;
      end_freq_ff       <= end_freq_in;
      diff_ff           <= diff_in;
      rise_ff           <= rise_in;
      t_ff              <= t_in;
      g_ff              <= g_in;
      prod_ff           <= prod_in;
      rsp_divisor_ff    <= rsp_divisor_in;
      rsp_speaker_on_ff <= rsp_speaker_on_in;
      rsp_busy_res_ff   <= rsp_busy_res_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_divisor    = rsp_divisor_ff;
   assign rsp_speaker_on = rsp_speaker_on_ff;
   assign rsp_busy_res   = rsp_busy_res_ff;

   `TGD_ASSERT_IMPLIES(a_ready_div_idle, req_ready, !div_stat.busy, "ready while divider busy")
   `TGD_ASSERT_IMPLIES(a_done_in_wait, div_stat.done, (state_ff == S_TDIV) || (state_ff == S_DIV), "divider finished outside a wait state")
   `TGD_ASSERT_IMPLIES(a_progress_below_one, state_ff == S_MUL1, elapsed_ff < length_ff, "slide progress reached one")
   `TGD_ASSERT_IMPLIES(a_speaker_needs_busy, rsp_valid_ff && rsp_speaker_on_ff, rsp_busy_res_ff, "speaker on while not busy")
   `TGD_ASSERT_NEXT(a_idle_tick_keeps_div, accept && (req_kind == KIND_TICK) && (mode_ff == MODE_IDLE), $stable(cur_div_ff), "idle tick changed the divisor")

endmodule

// ----- src/tgd_divider.sv -----
// Restoring divider that retires one quotient bit per cycle while busy and flags quotient overflow.
// Depends on tgd_pkg for the status type.
module tgd_divider
   import tgd_pkg::*;
#(
   parameter int NUM_WIDTH = 36,
   parameter int DEN_WIDTH = 26,
   parameter int QUO_WIDTH = TIMER_DIV_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numerator,
   input  logic [DEN_WIDTH-1:0] denominator,
   output logic [QUO_WIDTH-1:0] quotient,
   output div_status_type       status
);

   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [DEN_WIDTH-1:0] rem_ff, rem_in;
   logic [QUO_WIDTH-1:0] quo_ff, quo_in;
   logic [DEN_WIDTH:0]   rem_shift;
   logic [DEN_WIDTH+1:0] trial;
   logic                 fits;

   assign rem_shift = {rem_ff, num_ff[NUM_WIDTH-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, den_ff};
   assign fits      = ~trial[DEN_WIDTH+1];

   // A zero denominator sets every quotient bit and the overflow flag; the core saturates the divisor on overflow.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         ovf_in  = 1'b0;
         cnt_in  = CW'(NUM_WIDTH);
         num_in  = numerator;
         den_in  = denominator;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_WIDTH-2:0], 1'b0};
         rem_in = fits ? trial[DEN_WIDTH-1:0] : rem_shift[DEN_WIDTH-1:0];
         quo_in = {quo_ff[QUO_WIDTH-2:0], fits};
         ovf_in = ovf_ff | quo_ff[QUO_WIDTH-1];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient        = quo_ff;
   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;

endmodule
